/* rtl/core/v2y_pkg.sv */
`default_nettype none

package v2y_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int WORD_W          = 32;
  localparam int HELD_W          = 30;
  localparam int CFG_W           = 13;
  localparam int IDX_W           = 2;
  localparam int WIL_W           = 12;
  localparam int SAMPLE_W        = 8;

  localparam int BLOCK_ROUND = 47;
  localparam int BLOCK_WORDS = 32;
  // floor(n / 3) == (n * 683) >> 11 for every n below 2048
  localparam int DIV3_MUL    = 683;
  localparam int DIV3_SHIFT  = 11;

  localparam int SHIFT_LOW  = 2;
  localparam int SHIFT_MID  = 12;
  localparam int SHIFT_HIGH = 22;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);
  localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_LINE_PIXELS);

  localparam logic [IDX_W-1:0] REG_ACTIVE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ACTIVE_HEIGHT = IDX_W'(1);

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } word_pos_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  index;
    logic [CFG_W-1:0]  data;
  } cfg_wr_t;

  // one accepted word after position tracking
  typedef struct packed {
    logic [HELD_W-1:0] cur;
    logic [HELD_W-1:0] prev;
    word_pos_t         pos;
    logic              emit;
    logic              line_end;
    logic              frame_end;
  } slot_t;

  // words per line: ceil(w / 48) blocks of 32 words, never less than one block
  function automatic logic [CFG_W-1:0] words_per_line(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] x;
    logic [8:0]       n;
    logic [18:0]      prod;
    logic [7:0]       q;
    x    = w + CFG_W'(BLOCK_ROUND);
    n    = x[CFG_W-1:4];
    prod = {10'd0, n} * 19'(DIV3_MUL);
    q    = prod[DIV3_SHIFT +: 8];
    return (q == 8'd0) ? CFG_W'(BLOCK_WORDS) : {q, 5'd0};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/v2y_if.sv */
`default_nettype none

interface v2y_word_if import v2y_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink   (input valid, input packed_word, output ready);
endinterface

interface v2y_pair_if import v2y_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_first;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] luma_second;
  logic [SAMPLE_W-1:0] chroma_red;
  logic                line_end;
  logic                frame_end;

  modport source (output valid, output luma_first, output chroma_blue,
                  output luma_second, output chroma_red, output line_end,
                  output frame_end, input ready);
  modport sink   (input valid, input luma_first, input chroma_blue,
                  input luma_second, input chroma_red, input line_end,
                  input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/v2y_track.sv */
`default_nettype none

module v2y_track import v2y_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_wr_t           cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_word,
  output logic                   slot_valid,
  input  wire logic              slot_ready,
  output slot_t                  slot
);

  logic [CFG_W-1:0]  active_width;
  logic [CFG_W-1:0]  active_height;
  logic [HELD_W-1:0] held_word;
  logic [WIL_W-1:0]  word_in_line;
  logic [CFG_W-1:0]  pixels_done;
  logic [CFG_W-1:0]  line_count;

  logic [CFG_W-1:0]  eff_w;
  logic [CFG_W-1:0]  even_w;
  logic [CFG_W-1:0]  wpl;
  logic [CFG_W-1:0]  height;
  logic [CFG_W-1:0]  pixels_inc;
  logic [CFG_W-1:0]  wil_inc;
  logic [CFG_W:0]    line_inc;
  logic              emit;
  logic              last_line;
  logic              wrap;
  logic              take;

  assign in_ready = !rst && (!slot_valid || slot_ready);
  assign take     = in_valid && in_ready;

  always_comb begin
    eff_w      = (active_width > WIDTH_MAX) ? WIDTH_MAX : active_width;
    even_w     = {eff_w[CFG_W-1:1], 1'b0};
    wpl        = words_per_line(eff_w);
    height     = (active_height == '0) ? CFG_W'(1) : active_height;
    emit       = (word_in_line[1:0] != POS_FIRST) && (pixels_done < even_w);
    pixels_inc = pixels_done + CFG_W'(2);
    last_line  = (pixels_inc == even_w);
    wil_inc    = {1'b0, word_in_line} + CFG_W'(1);
    wrap       = (wil_inc >= wpl);
    line_inc   = {1'b0, line_count} + (CFG_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= WIDTH_RESET;
      active_height <= HEIGHT_RESET;
      held_word     <= '0;
      word_in_line  <= '0;
      pixels_done   <= '0;
      line_count    <= '0;
      slot_valid    <= 1'b0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          REG_ACTIVE_WIDTH:  active_width  <= cfg.data;
          REG_ACTIVE_HEIGHT: active_height <= cfg.data;
          default: ;
        endcase
      end
      if (take) begin
        held_word  <= in_word[HELD_W-1:0];
        slot_valid <= 1'b1;
        if (wrap) begin
          word_in_line <= '0;
          pixels_done  <= '0;
          line_count   <= (line_inc >= {1'b0, height}) ? '0 : line_inc[CFG_W-1:0];
        end else begin
          word_in_line <= wil_inc[WIL_W-1:0];
          if (emit) begin
            pixels_done <= pixels_inc;
          end
        end
      end else if (slot_ready) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot.cur       <= in_word[HELD_W-1:0];
      slot.prev      <= held_word;
      slot.pos       <= word_pos_t'(word_in_line[1:0]);
      slot.emit      <= emit;
      slot.line_end  <= last_line;
      slot.frame_end <= last_line && (line_count == height - CFG_W'(1));
    end
  end

endmodule

`default_nettype wire

/* rtl/core/v2y_pick.sv */
`default_nettype none

module v2y_pick import v2y_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   slot_valid,
  output logic        slot_ready,
  input  wire slot_t  slot,
  v2y_pair_if.source  pairs
);

  logic [SAMPLE_W-1:0] y0_next;
  logic [SAMPLE_W-1:0] cb_next;
  logic [SAMPLE_W-1:0] y1_next;
  logic [SAMPLE_W-1:0] cr_next;
  logic                load;

  assign slot_ready = !pairs.valid || pairs.ready;
  assign load       = slot_valid && slot_ready;

  always_comb begin
    case (slot.pos)
      POS_SECOND: begin
        y0_next = slot.prev[SHIFT_MID  +: SAMPLE_W];
        cb_next = slot.prev[SHIFT_LOW  +: SAMPLE_W];
        y1_next = slot.cur [SHIFT_LOW  +: SAMPLE_W];
        cr_next = slot.prev[SHIFT_HIGH +: SAMPLE_W];
      end
      POS_THIRD: begin
        y0_next = slot.prev[SHIFT_HIGH +: SAMPLE_W];
        cb_next = slot.prev[SHIFT_MID  +: SAMPLE_W];
        y1_next = slot.cur [SHIFT_MID  +: SAMPLE_W];
        cr_next = slot.cur [SHIFT_LOW  +: SAMPLE_W];
      end
      default: begin
        // fourth word; the first word of a group never emits
        y0_next = slot.cur [SHIFT_LOW  +: SAMPLE_W];
        cb_next = slot.prev[SHIFT_HIGH +: SAMPLE_W];
        y1_next = slot.cur [SHIFT_HIGH +: SAMPLE_W];
        cr_next = slot.cur [SHIFT_MID  +: SAMPLE_W];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs.valid <= 1'b0;
    end else if (load) begin
      pairs.valid <= slot.emit;
    end else if (pairs.ready) begin
      pairs.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot.emit) begin
      pairs.luma_first  <= y0_next;
      pairs.chroma_blue <= cb_next;
      pairs.luma_second <= y1_next;
      pairs.chroma_red  <= cr_next;
      pairs.line_end    <= slot.line_end;
      pairs.frame_end   <= slot.frame_end;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/v210_to_yuyv_unpacker_core.sv */
// channel   dir  payload                                         transfer when
// words     in   packed_word[31:0]                               valid && ready
// pairs     out  luma_first, chroma_blue, luma_second,           valid && ready
//                chroma_red (8 b each), line_end, frame_end
// cfg       in   cfg_index[1:0], cfg_data[12:0]                  cfg_we
//
// One word per clock sustained while the output is not stalled; each pair
// passes the track slot register, then the pick output register.
// The word-position tracker is a single register stage ahead of the picker.
// rst is synchronous: counters clear, width 1920 and height 1080 load.
// A stalled output holds its pair; both stages fill before words stop.
`default_nettype none

module v210_to_yuyv_unpacker_core import v2y_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  v2y_word_if.sink              words,
  v2y_pair_if.source            pairs,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_wr_t cfg;
  slot_t   slot;
  logic    slot_valid;
  logic    slot_ready;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  v2y_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (words.valid),
    .in_ready   (words.ready),
    .in_word    (words.packed_word),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot)
  );

  v2y_pick u_pick (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot),
    .pairs      (pairs)
  );

endmodule

`default_nettype wire

/* rtl/core/v2y_checker.sv */
`default_nettype none

module v2y_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] luma_first,
  input wire logic [7:0] chroma_blue,
  input wire logic [7:0] luma_second,
  input wire logic [7:0] chroma_red,
  input wire logic       line_end,
  input wire logic       frame_end
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pair valid right after reset");

  a_frame_implies_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> line_end)
    else $error("frame end without line end");

  // input only backs up when the output is full and stalled
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(luma_first)
      && $stable(chroma_blue) && $stable(luma_second) && $stable(chroma_red)
      && $stable(line_end) && $stable(frame_end))
    else $error("stalled pair changed");

endmodule

bind v210_to_yuyv_unpacker_core v2y_checker u_v2y_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (words.ready),
  .out_valid   (pairs.valid),
  .out_ready   (pairs.ready),
  .luma_first  (pairs.luma_first),
  .chroma_blue (pairs.chroma_blue),
  .luma_second (pairs.luma_second),
  .chroma_red  (pairs.chroma_red),
  .line_end    (pairs.line_end),
  .frame_end   (pairs.frame_end)
);

`default_nettype wire
